// ===== rtl/fbpf_pkg.sv =====
// ----------------------------------------------------------------------------
// Framebuffer pixel format package
// Shared widths, register codes, reciprocal table and the types that pass
// between the lanes, the address unit and the merge stage.
// ----------------------------------------------------------------------------
`default_nettype none

package fbpf_pkg;

	// Fixed field widths of the pixel port.
	localparam int ADDR_BITS        = 26;
	localparam int MAX_CHANNEL_BITS = 16;
	localparam int CHAN_NUM         = 4;
	localparam int CHAN_FIELD_W     = 5;
	localparam int CFG_DATA_W       = 24;
	localparam int IN_DATA_W        = 96;
	localparam int OUT_DATA_W       = 96;

	// Lane arithmetic: numerator, reciprocal and product widths.
	localparam int NUM_W   = 24;
	localparam int RECIP_W = 26;
	localparam int PROD_W  = NUM_W + RECIP_W;

	// Encoding divides by 255 through a multiply by ceil(2^32 / 255).
	localparam logic [RECIP_W-1:0] RECIP_255    = 26'd16843010;
	localparam int                 ENC_SHIFT    = 32;
	localparam int                 DEC_SHIFT    = 24;
	localparam logic [7:0]         ENC_BIAS     = 8'd127;
	localparam logic [7:0]         ALPHA_OPAQUE = 8'd255;

	// Store sizes in bytes.
	localparam logic [2:0] BYTES_NONE = 3'd0;
	localparam logic [2:0] BYTES_HALF = 3'd2;
	localparam logic [2:0] BYTES_WORD = 3'd4;

	// Channel order inside the packed shift and length registers.
	localparam int CH_RED   = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 2;
	localparam int CH_ALPHA = 3;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_FRAME_WIDTH    = 3'd0,
		REG_FRAME_HEIGHT   = 3'd1,
		REG_LINE_BYTES     = 3'd2,
		REG_PAGE_OFFSET    = 3'd3,
		REG_WIDE_PIXELS    = 3'd4,
		REG_CHANNEL_SHIFTS = 3'd5,
		REG_CHANNEL_WIDTHS = 3'd6
	} fbpf_reg_t;

	// Request kinds.
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_READ  = 1'b1;

	typedef struct packed {
		logic [12:0] frame_width;
		logic [12:0] frame_height;
		logic [14:0] line_bytes;
		logic [23:0] page_offset;
		logic        wide_pixels;
		logic [19:0] channel_shifts;
		logic [19:0] channel_widths;
	} fbpf_cfg_t;

	// Per-stage advance strobes of the pipeline.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} fbpf_adv_t;

	typedef struct packed {
		logic             in_bounds;
		logic [ADDR_BITS-1:0] byte_address;
		logic [31:0]      store_word;
		logic [2:0]       store_bytes;
		logic [7:0]       red_out;
		logic [7:0]       green_out;
		logic [7:0]       blue_out;
		logic [7:0]       alpha_out;
	} fbpf_out_t;

	// Decoding divides by m = 2^len - 1 through a multiply by
	// 2^24 + ceil(2^24 / m) and a right shift by 24 + len.
	function automatic logic [RECIP_W-1:0] recip_for_len(input logic [4:0] len);
		logic [RECIP_W-1:0] r;
		case (len)
			5'd1:    r = 26'd33554432;
			5'd2:    r = 26'd22369622;
			5'd3:    r = 26'd19173962;
			5'd4:    r = 26'd17895698;
			5'd5:    r = 26'd17318417;
			5'd6:    r = 26'd17043522;
			5'd7:    r = 26'd16909321;
			5'd8:    r = 26'd16843010;
			5'd9:    r = 26'd16810049;
			5'd10:   r = 26'd16793617;
			5'd11:   r = 26'd16785413;
			5'd12:   r = 26'd16781314;
			5'd13:   r = 26'd16779265;
			5'd14:   r = 26'd16778241;
			5'd15:   r = 26'd16777729;
			5'd16:   r = 26'd16777473;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/fbpf_lane.sv =====
// ----------------------------------------------------------------------------
// Pixel format channel lane
// Scales one colour channel between 8 bits and its configured length, in two
// stages: numerator forming, then a reciprocal multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpf_lane (
	input  wire logic                clk,
	input  wire fbpf_pkg::fbpf_adv_t adv,
	input  wire logic                is_read,
	input  wire logic [7:0]          value,
	input  wire logic [31:0]         word,
	input  wire logic [4:0]          chan_shift,
	input  wire logic [4:0]          chan_len,
	output logic [15:0]              quot,
	output logic                     len_zero
);
	import fbpf_pkg::*;

	logic [4:0]         len_sat;
	logic [15:0]        mask;
	logic [15:0]        field;
	logic [NUM_W-1:0]   num_enc;
	logic [NUM_W-1:0]   num_dec;
	logic [RECIP_W-1:0] recip;
	logic [NUM_W-1:0]   num_s1;
	logic               rd_s1;
	logic [PROD_W-1:0]  prod_s2;
	logic               rd_s2;

	// Channel length saturates at the widest supported field.
	always_comb begin
		len_sat  = (chan_len > 5'(MAX_CHANNEL_BITS)) ? 5'(MAX_CHANNEL_BITS) : chan_len;
		mask     = 16'((17'd1 << len_sat) - 17'd1);
		len_zero = (len_sat == 5'd0);
	end

	// Numerators: v * m + 127 for a write, f * 255 + m / 2 for a read.
	always_comb begin
		field   = 16'(word >> chan_shift) & mask;
		num_enc = (NUM_W'(value) << len_sat) - NUM_W'(value) + NUM_W'(ENC_BIAS);
		num_dec = (NUM_W'(field) << 8) - NUM_W'(field) + NUM_W'(mask >> 1);
	end

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			num_s1 <= is_read ? num_dec : num_enc;
			rd_s1  <= is_read;
		end
	end

	// Reciprocal multiply replaces the division.
	assign recip = rd_s1 ? recip_for_len(len_sat) : RECIP_255;

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			prod_s2 <= PROD_W'(num_s1) * PROD_W'(recip);
			rd_s2   <= rd_s1;
		end
	end

	// The quotient is the product's upper bits.
	always_comb begin
		if (rd_s2) begin
			quot = 16'(prod_s2 >> (6'(DEC_SHIFT) + 6'(len_sat)));
		end else begin
			quot = prod_s2[ENC_SHIFT +: 16];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/fbpf_addr.sv =====
// ----------------------------------------------------------------------------
// Pixel address unit
// Checks the coordinates against the frame and forms the byte address of
// the pixel over two stages.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpf_addr (
	input  wire logic                          clk,
	input  wire fbpf_pkg::fbpf_adv_t           adv,
	input  wire fbpf_pkg::fbpf_cfg_t           cfg,
	input  wire logic signed [15:0]            x_pos,
	input  wire logic signed [15:0]            y_pos,
	output logic                               in_bounds,
	output logic [fbpf_pkg::ADDR_BITS-1:0]     byte_address
);
	import fbpf_pkg::*;

	logic                 inb;
	logic [27:0]          y_prod;
	logic [14:0]          x_off;
	logic                 inb_s1;
	logic [ADDR_BITS-1:0] y_prod_s1;
	logic [14:0]          x_off_s1;
	logic                 inb_s2;
	logic [ADDR_BITS-1:0] addr_s2;

	// Negative coordinates fail on the sign bit alone.
	always_comb begin
		inb = !x_pos[15] && !y_pos[15]
			&& (x_pos[14:0] < 15'(cfg.frame_width))
			&& (y_pos[14:0] < 15'(cfg.frame_height));
		y_prod = 28'(y_pos[12:0]) * 28'(cfg.line_bytes);
		x_off  = cfg.wide_pixels ? {x_pos[12:0], 2'b00} : {1'b0, x_pos[12:0], 1'b0};
	end

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			inb_s1    <= inb;
			y_prod_s1 <= y_prod[ADDR_BITS-1:0];
			x_off_s1  <= x_off;
		end
	end

	// The sum wraps at the address width.
	always_ff @(posedge clk) begin
		if (adv.s2) begin
			inb_s2  <= inb_s1;
			addr_s2 <= ADDR_BITS'(cfg.page_offset) + y_prod_s1 + ADDR_BITS'(x_off_s1);
		end
	end

	assign in_bounds    = inb_s2;
	assign byte_address = addr_s2;

endmodule

`default_nettype wire

// ===== rtl/fbpf_merge.sv =====
// ----------------------------------------------------------------------------
// Pixel format merge stage
// Combines the four lane results into the store word or the decoded colour
// and holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpf_merge (
	input  wire logic                                 clk,
	input  wire fbpf_pkg::fbpf_adv_t                  adv,
	input  wire logic                                 wide_pixels,
	input  wire logic [19:0]                          channel_shifts,
	input  wire logic                                 is_read,
	input  wire logic                                 in_bounds,
	input  wire logic [fbpf_pkg::ADDR_BITS-1:0]       byte_address,
	input  wire logic [fbpf_pkg::CHAN_NUM-1:0][15:0]  quot,
	input  wire logic [fbpf_pkg::CHAN_NUM-1:0]        len_zero,
	output fbpf_pkg::fbpf_out_t                       result
);
	import fbpf_pkg::*;

	logic [46:0] placed;
	logic [31:0] enc_word;
	fbpf_out_t   res;
	fbpf_out_t   res_s3;

	// Place each encoded channel at its offset; bits above 31 drop out.
	always_comb begin
		placed   = '0;
		enc_word = '0;
		for (int c = 0; c < CHAN_NUM; c++) begin
			placed   = 47'(quot[c]) << channel_shifts[c*CHAN_FIELD_W +: CHAN_FIELD_W];
			enc_word = enc_word | placed[31:0];
		end
		if (!wide_pixels) begin
			enc_word[31:16] = '0;
		end
	end

	// Out-of-bounds requests give an all-zero result.
	always_comb begin
		res = '0;
		if (in_bounds) begin
			res.in_bounds    = 1'b1;
			res.byte_address = byte_address;
			if (is_read == ACT_READ) begin
				res.red_out   = len_zero[CH_RED]   ? 8'd0 : quot[CH_RED][7:0];
				res.green_out = len_zero[CH_GREEN] ? 8'd0 : quot[CH_GREEN][7:0];
				res.blue_out  = len_zero[CH_BLUE]  ? 8'd0 : quot[CH_BLUE][7:0];
				res.alpha_out = len_zero[CH_ALPHA] ? ALPHA_OPAQUE : quot[CH_ALPHA][7:0];
			end else begin
				res.store_word  = enc_word;
				res.store_bytes = wide_pixels ? BYTES_WORD : BYTES_HALF;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			res_s3 <= res;
		end
	end

	assign result = res_s3;

endmodule

`default_nettype wire

// ===== rtl/framebuffer_pixel_format_port.sv =====
// ----------------------------------------------------------------------------
// Framebuffer pixel format port
// Bounds check, byte addressing and RGBA8888 to bitfield conversion for one
// pixel access per clock while results are accepted.
// ----------------------------------------------------------------------------
// The block takes one pixel request per clock and passes it through its stages:
// one stage forms the lane numerators and the row product, one multiplies each
// lane by its reciprocal and sums the address, and the output register holds the
// merged result. Four lanes, one per colour channel, each own a 24 by 26 bit
// multiplier that runs every cycle, so the sustained rate is one request per clock
// while the result side accepts. Configuration is taken through the write port;
// the user is to write it only while the block is idle; the block does not enforce it.
`default_nettype none

module framebuffer_pixel_format_port (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// Request stream.
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// x_pos[15:0], y_pos[31:16], red_in[39:32], green_in[47:40],
	// blue_in[55:48], alpha_in[63:56], raw_word[95:64]
	input  wire logic [fbpf_pkg::IN_DATA_W-1:0]      s_tdata,
	// action[0]
	input  wire logic                                s_tuser,
	// Result stream.
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// byte_address[25:0], store_word[57:26], store_bytes[60:58],
	// red_out[68:61], green_out[76:69], blue_out[84:77], alpha_out[92:85],
	// zero[95:93]
	output logic [fbpf_pkg::OUT_DATA_W-1:0]          m_tdata,
	// in_bounds[0]
	output logic                                     m_tuser,
	// Configuration write port.
	input  wire logic                                cfg_we,
	input  wire logic [2:0]                          cfg_index,
	input  wire logic [fbpf_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import fbpf_pkg::*;

	fbpf_cfg_t                     cfg_q;
	fbpf_adv_t                     adv;
	logic                          v_s1;
	logic                          v_s2;
	logic                          v_s3;
	logic                          rd_s1;
	logic                          rd_s2;
	logic                          accept;
	logic [31:0]                   word;
	logic                          in_b;
	logic [ADDR_BITS-1:0]          addr;
	logic [CHAN_NUM-1:0][15:0]     quot;
	logic [CHAN_NUM-1:0]           len_zero;
	fbpf_out_t                     result;

	// Configuration registers; all clear at reset except the pixel size.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{13'd0, 13'd0, 15'd0, 24'd0, 1'b1, 20'd0, 20'd0};
		end else if (cfg_we) begin
			case (fbpf_reg_t'(cfg_index))
				REG_FRAME_WIDTH:    cfg_q.frame_width    <= cfg_data[12:0];
				REG_FRAME_HEIGHT:   cfg_q.frame_height   <= cfg_data[12:0];
				REG_LINE_BYTES:     cfg_q.line_bytes     <= cfg_data[14:0];
				REG_PAGE_OFFSET:    cfg_q.page_offset    <= cfg_data[23:0];
				REG_WIDE_PIXELS:    cfg_q.wide_pixels    <= cfg_data[0];
				REG_CHANNEL_SHIFTS: cfg_q.channel_shifts <= cfg_data[19:0];
				REG_CHANNEL_WIDTHS: cfg_q.channel_widths <= cfg_data[19:0];
				default:            cfg_q                <= cfg_q;
			endcase
		end
	end

	// Each stage moves on when it is empty or its successor moves on.
	always_comb begin
		adv.s3 = !v_s3 || m_tready;
		adv.s2 = !v_s2 || adv.s3;
		adv.s1 = !v_s1 || adv.s2;
	end

	assign s_tready = adv.s1;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv.s1) begin
				v_s1 <= accept;
			end
			if (adv.s2) begin
				v_s2 <= v_s1;
			end
			if (adv.s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// The request kind travels alongside the lanes.
	always_ff @(posedge clk) begin
		if (adv.s1) begin
			rd_s1 <= s_tuser;
		end
		if (adv.s2) begin
			rd_s2 <= rd_s1;
		end
	end

	// Sixteen-bit pixels see only the low half of the memory word.
	assign word = cfg_q.wide_pixels ? s_tdata[95:64] : {16'd0, s_tdata[79:64]};

	fbpf_addr u_addr (
		.clk          (clk),
		.adv          (adv),
		.cfg          (cfg_q),
		.x_pos        (s_tdata[15:0]),
		.y_pos        (s_tdata[31:16]),
		.in_bounds    (in_b),
		.byte_address (addr)
	);

	// One lane per colour channel.
	for (genvar c = 0; c < CHAN_NUM; c++) begin : g_lane
		fbpf_lane u_lane (
			.clk        (clk),
			.adv        (adv),
			.is_read    (s_tuser),
			.value      (s_tdata[32 + 8*c +: 8]),
			.word       (word),
			.chan_shift (cfg_q.channel_shifts[c*CHAN_FIELD_W +: CHAN_FIELD_W]),
			.chan_len   (cfg_q.channel_widths[c*CHAN_FIELD_W +: CHAN_FIELD_W]),
			.quot       (quot[c]),
			.len_zero   (len_zero[c])
		);
	end

	fbpf_merge u_merge (
		.clk            (clk),
		.adv            (adv),
		.wide_pixels    (cfg_q.wide_pixels),
		.channel_shifts (cfg_q.channel_shifts),
		.is_read        (rd_s2),
		.in_bounds      (in_b),
		.byte_address   (addr),
		.quot           (quot),
		.len_zero       (len_zero),
		.result         (result)
	);

	// Result stream packing.
	assign m_tvalid = v_s3;
	assign m_tuser  = result.in_bounds;
	assign m_tdata  = {3'd0, result.alpha_out, result.blue_out, result.green_out,
		result.red_out, result.store_bytes, result.store_word, result.byte_address};

	// Store sizes are none, a half word or a word.
	a_store_size: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[60:58] == BYTES_NONE || m_tdata[60:58] == BYTES_HALF
			|| m_tdata[60:58] == BYTES_WORD))
		else $error("store size outside none, half word and word");

	// An out-of-bounds request yields an all-zero payload.
	a_oob_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata == '0))
		else $error("out-of-bounds result carries data");

	// An accepted request always occupies the first stage next cycle.
	a_accept_fill: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> v_s1)
		else $error("accepted request lost from the first stage");

	// A stalled result keeps the stage behind it from being overwritten.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !m_tready && v_s2) |=> (v_s3 && v_s2))
		else $error("stalled pipeline dropped a request");

endmodule

`default_nettype wire

// ===== bench/tb_framebuffer_pixel_format_port.sv =====
// ----------------------------------------------------------------------------
// Framebuffer pixel format port testbench
// Sends pixel write and read requests through a range of frame geometries and
// channel layouts, and checks each result against a behavioural model of the
// bounds check, address arithmetic and channel encode and decode.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_framebuffer_pixel_format_port;

	import fbpf_pkg::*;

	// One pixel request as it travels on the request stream.
	typedef struct packed {
		logic        action;
		logic [15:0] x_pos;
		logic [15:0] y_pos;
		logic [7:0]  red_in;
		logic [7:0]  green_in;
		logic [7:0]  blue_in;
		logic [7:0]  alpha_in;
		logic [31:0] raw_word;
	} pixel_req_t;

	localparam int unsigned LONG_HOLD      = 400;
	localparam int unsigned WATCHDOG_LIMIT = 3000;
	localparam int unsigned RANDOM_FORMATS = 6;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;
	logic                  cfg_we = 1'b0;
	logic [2:0]            cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Register copy seen by the model; written only while the block is idle.
	fbpf_cfg_t    fmt_cfg;
	pixel_req_t   pixel_backlog[$];
	fbpf_out_t    pending_results[$];
	pixel_req_t   drv_req;
	logic         in_fire = 1'b0;
	bit           src_idle_on = 1'b0;
	bit           snk_idle_on = 1'b0;
	bit           hold_request = 1'b0;
	int unsigned  src_gap = 0;
	int unsigned  snk_hold = 0;
	int unsigned  idle_cycles = 0;
	int unsigned  fail_count = 0;
	int unsigned  n_checked = 0;
	int unsigned  n_writes = 0;
	int unsigned  n_reads = 0;
	int unsigned  n_outside = 0;
	int unsigned  n_formats = 0;
	int unsigned  n_held_off = 0;

	framebuffer_pixel_format_port i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// All-ones mask of a channel, with the length clamped to the widest field.
	function automatic longint unsigned chan_ones(logic [19:0] widths, int ch);
		int unsigned n;
		n = (widths >> (CHAN_FIELD_W * ch)) & 31;
		if (n > MAX_CHANNEL_BITS)
			n = MAX_CHANNEL_BITS;
		return (64'd1 << n) - 64'd1;
	endfunction

	function automatic int unsigned chan_offset(logic [19:0] shifts, int ch);
		return (shifts >> (CHAN_FIELD_W * ch)) & 31;
	endfunction

	// Expected result of one pixel request under the given register settings.
	function automatic fbpf_out_t pixel_outcome(fbpf_cfg_t c, pixel_req_t rq);
		fbpf_out_t         r;
		longint unsigned   addr;
		longint unsigned   word;
		longint unsigned   m;
		longint unsigned   f;
		longint unsigned   e;
		longint unsigned   bpp;
		logic [7:0]        chan_in [4];
		logic [7:0]        chan_dec [4];
		int                ch;
		r = '0;
		if (rq.x_pos[15] || rq.y_pos[15] || rq.x_pos >= c.frame_width ||
				rq.y_pos >= c.frame_height)
			return r;
		bpp = c.wide_pixels ? 4 : 2;
		addr = longint'(c.page_offset) + longint'(rq.y_pos) * longint'(c.line_bytes) +
			longint'(rq.x_pos) * bpp;
		r.in_bounds = 1'b1;
		r.byte_address = ADDR_BITS'(addr);
		chan_in = '{rq.red_in, rq.green_in, rq.blue_in, rq.alpha_in};
		if (rq.action == ACT_WRITE) begin
			// Scale each channel to its length with rounding, then place it.
			word = 0;
			for (ch = 0; ch < CHAN_NUM; ch++) begin
				m = chan_ones(c.channel_widths, ch);
				e = (longint'(chan_in[ch]) * m + 127) / 255;
				word |= (e << chan_offset(c.channel_shifts, ch)) & 64'hffff_ffff;
			end
			if (!c.wide_pixels)
				word &= 64'hffff;
			r.store_word = word[31:0];
			r.store_bytes = c.wide_pixels ? BYTES_WORD : BYTES_HALF;
		end else begin
			// Pull each field out of the memory word and widen it back to 8 bits.
			word = rq.raw_word;
			if (!c.wide_pixels)
				word &= 64'hffff;
			for (ch = 0; ch < CHAN_NUM; ch++) begin
				m = chan_ones(c.channel_widths, ch);
				if (m == 0) begin
					chan_dec[ch] = 8'd0;
				end else begin
					f = (word >> chan_offset(c.channel_shifts, ch)) & m;
					chan_dec[ch] = 8'((f * 255 + m / 2) / m);
				end
			end
			r.red_out = chan_dec[CH_RED];
			r.green_out = chan_dec[CH_GREEN];
			r.blue_out = chan_dec[CH_BLUE];
			r.alpha_out = (chan_ones(c.channel_widths, CH_ALPHA) == 0) ? ALPHA_OPAQUE :
				chan_dec[CH_ALPHA];
		end
		return r;
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Coordinates mostly inside the frame, some on its edge, some anywhere.
	function automatic logic [15:0] random_coord(logic [12:0] lim);
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 7 && lim != 0)
			return 16'($urandom_range(0, lim - 1));
		else if (r < 8)
			return 16'(lim) + 16'($urandom_range(0, 2)) - 16'd1;
		return 16'($urandom);
	endfunction

	function automatic logic [7:0] random_level();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 8'd0;
		else if (r == 1)
			return 8'd255;
		return 8'($urandom);
	endfunction

	function automatic pixel_req_t random_pixel(fbpf_cfg_t c);
		pixel_req_t p;
		int unsigned r;
		p.action = $urandom_range(0, 1) ? ACT_READ : ACT_WRITE;
		p.x_pos = random_coord(c.frame_width);
		p.y_pos = random_coord(c.frame_height);
		p.red_in = random_level();
		p.green_in = random_level();
		p.blue_in = random_level();
		p.alpha_in = random_level();
		r = $urandom_range(0, 9);
		p.raw_word = (r == 0) ? 32'h0 : (r == 1) ? 32'hffff_ffff : 32'($urandom);
		return p;
	endfunction

	function automatic fbpf_cfg_t make_format(logic [12:0] w, logic [12:0] h,
			logic [14:0] line, logic [23:0] page, logic wide, logic [19:0] shifts,
			logic [19:0] widths);
		fbpf_cfg_t c;
		c.frame_width = w;
		c.frame_height = h;
		c.line_bytes = line;
		c.page_offset = page;
		c.wide_pixels = wide;
		c.channel_shifts = shifts;
		c.channel_widths = widths;
		return c;
	endfunction

	function automatic fbpf_cfg_t random_format();
		logic [12:0] w;
		logic [12:0] h;
		w = $urandom_range(0, 3) == 0 ? 13'd4096 : 13'($urandom_range(1, 4096));
		h = $urandom_range(0, 3) == 0 ? 13'd1 : 13'($urandom_range(1, 4096));
		return make_format(w, h, 15'($urandom_range(0, 16384)),
			24'($urandom_range(0, 24'hffffff)), 1'($urandom_range(0, 1)),
			20'($urandom), 20'($urandom));
	endfunction

	// Register write; the bits above the register's width carry noise.
	task automatic write_reg(fbpf_reg_t idx, logic [23:0] value, int unsigned bits);
		logic [23:0] keep;
		logic [23:0] noise;
		keep = (24'd1 << bits) - 24'd1;
		noise = 24'($urandom);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= (value & keep) | (noise & ~keep);
	endtask

	// Wait for the block to go quiet, then load a complete register set.
	task automatic apply_format(fbpf_cfg_t c);
		while (pixel_backlog.size() != 0 || s_tvalid || pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
		write_reg(REG_FRAME_WIDTH, 24'(c.frame_width), 13);
		write_reg(REG_FRAME_HEIGHT, 24'(c.frame_height), 13);
		write_reg(REG_LINE_BYTES, 24'(c.line_bytes), 15);
		write_reg(REG_PAGE_OFFSET, c.page_offset, 24);
		write_reg(REG_WIDE_PIXELS, 24'(c.wide_pixels), 1);
		write_reg(REG_CHANNEL_SHIFTS, 24'(c.channel_shifts), 20);
		write_reg(REG_CHANNEL_WIDTHS, 24'(c.channel_widths), 20);
		@(negedge clk);
		cfg_we <= 1'b0;
		fmt_cfg = c;
		n_formats++;
	endtask

	task automatic queue_pixel(logic act, logic [15:0] x, logic [15:0] y,
			logic [31:0] colour, logic [31:0] raw);
		pixel_req_t p;
		p.action = act;
		p.x_pos = x;
		p.y_pos = y;
		{p.alpha_in, p.blue_in, p.green_in, p.red_in} = colour;
		p.raw_word = raw;
		pixel_backlog.push_back(p);
	endtask

	task automatic queue_random(int unsigned count);
		repeat (count) pixel_backlog.push_back(random_pixel(fmt_cfg));
	endtask

	task automatic check_field(string name, longint unsigned want, longint unsigned got);
		if (want != got) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
			fail_count++;
		end
	endtask

	// Request driver: offers the next queued request once the last one is taken.
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || in_fire)) begin
			if (src_gap > 0) begin
				src_gap--;
				s_tvalid <= 1'b0;
			end else if (pixel_backlog.size() != 0) begin
				drv_req = pixel_backlog.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {drv_req.raw_word, drv_req.alpha_in, drv_req.blue_in,
					drv_req.green_in, drv_req.red_in, drv_req.y_pos, drv_req.x_pos};
				s_tuser <= drv_req.action;
				src_gap = src_idle_on ? pick_gap() : 0;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Result sink: random stalls, plus one long hold-off on request.
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (snk_hold > 0) begin
			snk_hold--;
			m_tready <= 1'b0;
		end else if (hold_request) begin
			hold_request = 1'b0;
			snk_hold = LONG_HOLD - 1;
			m_tready <= 1'b0;
		end else if (snk_idle_on && $urandom_range(0, 3) == 0) begin
			snk_hold = pick_gap();
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Monitor: predict on each accepted request, compare each accepted result.
	always @(posedge clk) begin
		pixel_req_t rq;
		fbpf_out_t  want;
		fbpf_out_t  got;
		in_fire <= s_tvalid && s_tready;
		if (arst_n && s_tvalid && !s_tready)
			n_held_off++;
		if (arst_n && s_tvalid && s_tready) begin
			rq.action = s_tuser;
			{rq.raw_word, rq.alpha_in, rq.blue_in, rq.green_in, rq.red_in, rq.y_pos,
				rq.x_pos} = s_tdata;
			want = pixel_outcome(fmt_cfg, rq);
			pending_results.push_back(want);
			if (!want.in_bounds)
				n_outside++;
			else if (rq.action == ACT_WRITE)
				n_writes++;
			else
				n_reads++;
		end
		if (arst_n && m_tvalid && m_tready) begin
			got.in_bounds = m_tuser;
			{got.alpha_out, got.blue_out, got.green_out, got.red_out, got.store_bytes,
				got.store_word, got.byte_address} = m_tdata[92:0];
			if (pending_results.size() == 0) begin
				$error("result with no request outstanding");
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("in_bounds", want.in_bounds, got.in_bounds);
				check_field("byte_address", want.byte_address, got.byte_address);
				check_field("store_word", want.store_word, got.store_word);
				check_field("store_bytes", want.store_bytes, got.store_bytes);
				check_field("red_out", want.red_out, got.red_out);
				check_field("green_out", want.green_out, got.green_out);
				check_field("blue_out", want.blue_out, got.blue_out);
				check_field("alpha_out", want.alpha_out, got.alpha_out);
				n_checked++;
			end
		end
	end

	// Watchdog: counts busy cycles in which neither stream moves.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(pixel_backlog.size() == 0 && !s_tvalid && pending_results.size() == 0)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("framebuffer_pixel_format_port test failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		fmt_cfg = make_format(13'd0, 13'd0, 15'd0, 24'd0, 1'b1, 20'd0, 20'd0);
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Eight bits per channel, 32 bits per pixel; full idling on both sides.
		src_idle_on = 1'b1;
		snk_idle_on = 1'b1;
		apply_format(make_format(13'd320, 13'd240, 15'd1280, 24'h002000, 1'b1,
			{5'd24, 5'd16, 5'd8, 5'd0}, {5'd8, 5'd8, 5'd8, 5'd8}));
		queue_pixel(ACT_WRITE, 16'd0, 16'd0, 32'h0000_0000, 32'h0);
		queue_pixel(ACT_WRITE, 16'd319, 16'd239, 32'hffff_ffff, 32'h0);
		queue_pixel(ACT_WRITE, 16'd5, 16'd7, 32'h7856_3412, 32'h0);
		queue_pixel(ACT_READ, 16'd0, 16'd0, 32'h0, 32'h0000_0000);
		queue_pixel(ACT_READ, 16'd319, 16'd239, 32'h0, 32'hffff_ffff);
		queue_pixel(ACT_READ, 16'd10, 16'd3, 32'h0, 32'h8040_2010);
		queue_pixel(ACT_WRITE, 16'd320, 16'd0, 32'hffff_ffff, 32'h0);
		queue_pixel(ACT_READ, 16'd0, 16'd240, 32'h0, 32'hffff_ffff);
		queue_pixel(ACT_WRITE, 16'hffff, 16'd0, 32'hffff_ffff, 32'h0);
		queue_pixel(ACT_READ, 16'd0, 16'hffff, 32'h0, 32'hffff_ffff);
		queue_pixel(ACT_WRITE, 16'h8000, 16'h8000, 32'hffff_ffff, 32'h0);
		queue_pixel(ACT_READ, 16'h7fff, 16'h7fff, 32'h0, 32'hffff_ffff);
		// Long result-side hold-off while the requests keep coming.
		hold_request = 1'b1;
		queue_random(200);

		// Five-six-five layout in 16-bit pixels, no alpha field; no idling.
		src_idle_on = 1'b0;
		snk_idle_on = 1'b0;
		apply_format(make_format(13'd800, 13'd600, 15'd1600, 24'h100000, 1'b0,
			{5'd0, 5'd0, 5'd5, 5'd11}, {5'd0, 5'd5, 5'd6, 5'd5}));
		queue_pixel(ACT_WRITE, 16'd1, 16'd1, 32'hffff_ffff, 32'h0);
		queue_pixel(ACT_WRITE, 16'd2, 16'd2, 32'hc820_4080, 32'h0);
		queue_pixel(ACT_READ, 16'd3, 16'd3, 32'h0, 32'hffff_ffff);
		queue_pixel(ACT_READ, 16'd4, 16'd4, 32'h0, 32'h1234_f81f);
		queue_random(200);

		// Largest frame and offsets: the address wraps, channel lengths clamp and
		// encoded bits run off the top of the word.
		src_idle_on = 1'b1;
		snk_idle_on = 1'b0;
		apply_format(make_format(13'd4096, 13'd4096, 15'd16384, 24'hffffff, 1'b1,
			20'hfffff, 20'hfffff));
		queue_pixel(ACT_WRITE, 16'd4095, 16'd4095, 32'hffff_ffff, 32'h0);
		queue_pixel(ACT_READ, 16'd4095, 16'd4095, 32'h0, 32'hffff_ffff);
		queue_pixel(ACT_WRITE, 16'd4096, 16'd0, 32'hffff_ffff, 32'h0);
		queue_pixel(ACT_READ, 16'd0, 16'd0, 32'h0, 32'h8000_0000);
		queue_random(200);

		// Empty frame: every access falls outside.
		src_idle_on = 1'b0;
		snk_idle_on = 1'b1;
		apply_format(make_format(13'd0, 13'd0, 15'd0, 24'd0, 1'b1, 20'd0, 20'd0));
		queue_pixel(ACT_WRITE, 16'd0, 16'd0, 32'hffff_ffff, 32'h0);
		queue_pixel(ACT_READ, 16'd0, 16'd0, 32'h0, 32'hffff_ffff);
		queue_random(30);

		// All channel lengths zero: writes store a zero word, reads give opaque black.
		src_idle_on = 1'b1;
		snk_idle_on = 1'b1;
		apply_format(make_format(13'd16, 13'd16, 15'd64, 24'd0, 1'b1, 20'($urandom),
			20'd0));
		queue_pixel(ACT_WRITE, 16'd3, 16'd4, 32'hffff_ffff, 32'h0);
		queue_pixel(ACT_READ, 16'd15, 16'd15, 32'h0, 32'hffff_ffff);
		queue_random(100);

		// Random geometries and channel layouts.
		repeat (RANDOM_FORMATS) begin
			src_idle_on = $urandom_range(0, 2) != 0;
			snk_idle_on = $urandom_range(0, 2) != 0;
			apply_format(random_format());
			queue_random(155);
		end

		while (pixel_backlog.size() != 0 || s_tvalid || pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Ran %0d pixel requests over %0d register settings: %0d writes, %0d reads,",
			n_writes + n_reads + n_outside, n_formats, n_writes, n_reads);
		$display("%0d outside the frame; %0d results checked; input held off %0d cycles.",
			n_outside, n_checked, n_held_off);
		if (fail_count == 0 && pending_results.size() == 0) begin
			$display("framebuffer_pixel_format_port test passed");
		end else begin
			$display("framebuffer_pixel_format_port test failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
